>>> design/hpnlb_pkg.sv
// ----------------------------------------------------------------------------
// hpnlb_pkg
// Shared types and constants of the host packet to nibble link bridge.
// ----------------------------------------------------------------------------
package hpnlb_pkg;

  localparam int unsigned NIB_W     = 4;
  localparam int unsigned BUF_DEPTH = 42;
  localparam int unsigned CNT_W     = 6;

  localparam int unsigned ADDR_NIBS      = 8;
  localparam int unsigned PAYLOAD_NIBS   = 32;
  localparam int unsigned FRAME_ADDR_POS = 2;
  localparam int unsigned FRAME_DATA_POS = 10;

  // reply positions in the cell row once all reply nibbles are shifted in
  localparam int unsigned LOAD_DATA_LO = 10;
  localparam int unsigned RDCR_DATA_LO = 34;

  localparam int unsigned DATA_ALIGNMENT = 16;
  localparam logic [32:0] MEMORY_LIMIT   = 33'h0_8000_0000;
  localparam logic [4:0]  MAX_PAYLOAD    = 5'd16;

  typedef logic [NIB_W-1:0] nib_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // host commands
  localparam logic [2:0] CMD_RD_MEM  = 3'd0;
  localparam logic [2:0] CMD_WR_MEM  = 3'd1;
  localparam logic [2:0] CMD_RD_CTRL = 3'd2;
  localparam logic [2:0] CMD_WR_CTRL = 3'd3;
  localparam logic [2:0] CMD_START   = 3'd4;
  localparam logic [2:0] CMD_STOP    = 3'd5;

  // status codes
  localparam logic [1:0] ST_NONE       = 2'd0;
  localparam logic [1:0] ST_TAKEN      = 2'd1;
  localparam logic [1:0] ST_SEQ_DROP   = 2'd2;
  localparam logic [1:0] ST_CHECK_FAIL = 2'd3;

  // control register checks
  localparam logic [15:0] CTRL_PAGE   = 16'h0002;
  localparam logic [7:0]  CTRL_RD_REG = 8'd16;
  localparam logic [7:0]  CTRL_WR_REG = 8'd17;
  localparam logic [4:0]  CTRL_SIZE   = 5'd8;

  // frame and reply lengths in nibbles
  localparam cnt_t TX_SHORT = CNT_W'(2);
  localparam cnt_t TX_BASE  = CNT_W'(10);
  localparam cnt_t TX_WRCR  = CNT_W'(18);
  localparam cnt_t TX_STORE = CNT_W'(42);
  localparam cnt_t RX_BASE  = CNT_W'(2);
  localparam cnt_t RX_RDCR  = CNT_W'(10);
  localparam cnt_t RX_LOAD  = CNT_W'(34);

  localparam logic [4:0] ACK_SIZE_MEM  = 5'd16;
  localparam logic [4:0] ACK_SIZE_CTRL = 5'd8;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_LOAD,
    MODE_STORE,
    MODE_RDCR,
    MODE_WRCR,
    MODE_STOP
  } mode_e;

  // input item, last field in the lowest bits
  typedef struct packed {
    nib_t        link_reply_nibble;
    logic        link_reply_valid;
    logic        link_accepts;
    logic [63:0] payload_high;
    logic [63:0] payload_low;
    logic [4:0]  payload_size;
    logic [31:0] address;
    logic [15:0] packet_seq;
    logic [2:0]  command;
    logic        packet_valid;
  } in_item_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [1:0]  status;
    logic        stop_pulse;
    logic        start_pulse;
    logic [63:0] ack_data_high;
    logic [63:0] ack_data_low;
    logic [4:0]  ack_size;
    logic [15:0] ack_seq;
    logic        ack_valid;
    logic        reply_ready;
    nib_t        send_nibble;
    logic        send_valid;
  } out_item_t;

  localparam int unsigned IN_ITEM_W  = $bits(in_item_t);
  localparam int unsigned OUT_ITEM_W = $bits(out_item_t);
  localparam int unsigned IN_DATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((OUT_ITEM_W + 7) / 8) * 8;

  typedef logic [BUF_DEPTH-1:0][NIB_W-1:0] row_t;

  typedef struct packed {
    logic load;
    logic skip_first;
    logic shift;
    nib_t shift_in;
  } chain_ctl_t;

endpackage

>>> design/hpnlb_cell.sv
// ----------------------------------------------------------------------------
// hpnlb_cell
// One nibble cell of the frame and reply row.
// ----------------------------------------------------------------------------
module hpnlb_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  hpnlb_pkg::nib_t load_nib_i,
  input  logic            shift_i,
  input  hpnlb_pkg::nib_t next_nib_i,
  output hpnlb_pkg::nib_t nib_o
);
  import hpnlb_pkg::*;

  nib_t nib_q, nib_d;

  always_comb begin
    nib_d = nib_q;
    if (load_i) begin
      nib_d = load_nib_i;
    end else if (shift_i) begin
      nib_d = next_nib_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nib_q <= nib_d;
  end

  assign nib_o = nib_q;

endmodule

>>> design/hpnlb_chain.sv
// ----------------------------------------------------------------------------
// hpnlb_chain
// Row of nibble cells: loads a frame, shifts it out at cell zero and shifts
// reply nibbles in at the top cell.
// ----------------------------------------------------------------------------
module hpnlb_chain (
  input  logic                  clk_i,
  input  hpnlb_pkg::chain_ctl_t ctl_i,
  input  logic [2:0]            command_i,
  input  logic [31:0]           address_i,
  input  logic [63:0]           payload_low_i,
  input  logic [63:0]           payload_high_i,
  output hpnlb_pkg::row_t       row_o
);
  import hpnlb_pkg::*;

  logic [BUF_DEPTH:0][NIB_W-1:0] frame;
  logic [127:0]                  payload;

  assign payload = {payload_high_i, payload_low_i};

  always_comb begin
    frame    = '0;
    frame[0] = NIB_W'(command_i);
    for (int i = 0; i < ADDR_NIBS; i++) begin
      frame[FRAME_ADDR_POS + i] = address_i[NIB_W*i +: NIB_W];
    end
    for (int i = 0; i < PAYLOAD_NIBS; i++) begin
      frame[FRAME_DATA_POS + i] = payload[NIB_W*i +: NIB_W];
    end
  end

  for (genvar g = 0; g < BUF_DEPTH; g++) begin : g_cell
    nib_t load_nib;
    nib_t next_nib;

    // first nibble already on the link: load the frame one place down
    assign load_nib = ctl_i.skip_first ? frame[g+1] : frame[g];

    if (g == BUF_DEPTH - 1) begin : g_top
      assign next_nib = ctl_i.shift_in;
    end else begin : g_mid
      assign next_nib = row_o[g+1];
    end

    hpnlb_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (ctl_i.load),
      .load_nib_i (load_nib),
      .shift_i    (ctl_i.shift),
      .next_nib_i (next_nib),
      .nib_o      (row_o[g])
    );
  end

endmodule

>>> design/hpnlb_ctrl.sv
// ----------------------------------------------------------------------------
// hpnlb_ctrl
// Transfer sequencer: packet checks, link counters, acknowledgement and
// sequence tracking.
// ----------------------------------------------------------------------------
module hpnlb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  hpnlb_pkg::in_item_t   item_i,
  input  hpnlb_pkg::row_t       row_i,
  output hpnlb_pkg::chain_ctl_t ctl_o,
  output hpnlb_pkg::out_item_t  res_o
);
  import hpnlb_pkg::*;

  mode_e       mode_q, mode_d;
  logic [15:0] exp_seq_q, exp_seq_d;
  logic        flush_q, flush_d;
  cnt_t        sent_q, sent_d, send_total_q, send_total_d;
  cnt_t        recv_q, recv_d, recv_total_q, recv_total_d;
  logic        send_valid_q, send_valid_d;
  nib_t        send_nib_q, send_nib_d;
  logic        reply_ready_q, reply_ready_d;

  logic        busy, sending, send_step, collecting, done, recv_step, may_take;
  logic        look, seq_ok, ok, mem_ok, take;
  logic [15:0] cur_seq;
  cnt_t        ntx, nrx;
  mode_e       new_mode;
  logic [32:0] addr_ext;

  assign busy       = (mode_q != MODE_IDLE);
  assign sending    = busy && (sent_q < send_total_q);
  assign send_step  = sending && item_i.link_accepts;
  assign collecting = busy && !sending;
  assign done       = collecting && (recv_q >= recv_total_q);
  assign recv_step  = collecting && !done && item_i.link_reply_valid;
  assign may_take   = !busy || (done && (mode_q != MODE_STOP));
  assign look       = may_take && item_i.packet_valid;
  // a packet taken on the completion tick carries the advanced number
  assign cur_seq    = done ? (exp_seq_q + 16'd1) : exp_seq_q;
  assign seq_ok     = (item_i.packet_seq == cur_seq);

  assign addr_ext = {1'b0, item_i.address};
  assign mem_ok   = ((item_i.address % 32'(DATA_ALIGNMENT)) == '0) &&
                    ((item_i.payload_size % 5'(DATA_ALIGNMENT)) == '0) &&
                    (item_i.payload_size <= MAX_PAYLOAD) &&
                    (addr_ext <= MEMORY_LIMIT) &&
                    ((addr_ext + 33'(item_i.payload_size)) <= MEMORY_LIMIT);

  // command decode
  always_comb begin
    ok       = 1'b0;
    ntx      = TX_BASE;
    nrx      = RX_BASE;
    new_mode = MODE_IDLE;
    case (item_i.command)
      CMD_RD_MEM: begin
        ok       = mem_ok;
        nrx      = RX_LOAD;
        new_mode = MODE_LOAD;
      end
      CMD_WR_MEM: begin
        ok       = mem_ok;
        ntx      = TX_STORE;
        new_mode = MODE_STORE;
      end
      CMD_RD_CTRL: begin
        ok       = ((item_i.address[31:16] == CTRL_PAGE) ||
                    (item_i.address[7:0] == CTRL_RD_REG)) &&
                   (item_i.payload_size == CTRL_SIZE);
        nrx      = RX_RDCR;
        new_mode = MODE_RDCR;
      end
      CMD_WR_CTRL: begin
        ok       = ((item_i.address[31:16] == CTRL_PAGE) ||
                    (item_i.address[7:0] == CTRL_WR_REG)) &&
                   (item_i.payload_size == CTRL_SIZE);
        ntx      = TX_WRCR;
        new_mode = MODE_WRCR;
      end
      CMD_START: begin
        ok       = 1'b1;
        new_mode = MODE_WRCR;
      end
      CMD_STOP: begin
        ok       = 1'b1;
        ntx      = TX_SHORT;
        new_mode = MODE_STOP;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign take = look && seq_ok && ok;

  // next state
  always_comb begin
    mode_d        = mode_q;
    exp_seq_d     = exp_seq_q;
    flush_d       = flush_q;
    sent_d        = sent_q;
    send_total_d  = send_total_q;
    recv_d        = recv_q;
    recv_total_d  = recv_total_q;
    send_valid_d  = send_valid_q;
    send_nib_d    = send_nib_q;
    reply_ready_d = reply_ready_q;

    if (send_step) begin
      send_nib_d   = row_i[0];
      sent_d       = sent_q + CNT_W'(1);
      send_valid_d = 1'b1;
    end
    if (collecting) begin
      send_valid_d  = 1'b0;
      reply_ready_d = 1'b1;
    end
    if (done) begin
      exp_seq_d     = exp_seq_q + 16'd1;
      mode_d        = MODE_IDLE;
      flush_d       = 1'b0;
      sent_d        = '0;
      send_total_d  = '0;
      recv_d        = '0;
      recv_total_d  = '0;
      reply_ready_d = 1'b0;
    end else if (recv_step) begin
      recv_d = recv_q + CNT_W'(1);
    end

    if (take) begin
      mode_d        = new_mode;
      flush_d       = (item_i.command == CMD_START);
      send_total_d  = ntx;
      recv_total_d  = nrx;
      sent_d        = '0;
      recv_d        = '0;
      send_nib_d    = NIB_W'(item_i.command);
      reply_ready_d = 1'b0;
      if (item_i.link_accepts) begin
        send_valid_d  = 1'b1;
        sent_d        = CNT_W'(1);
        reply_ready_d = (item_i.command >= CMD_START);
      end
    end
  end

  // result item and cell control
  always_comb begin
    res_o             = '0;
    res_o.send_valid  = send_valid_d;
    res_o.send_nibble = send_nib_d;
    res_o.reply_ready = reply_ready_d;
    res_o.ack_valid   = done;

    if (done) begin
      res_o.ack_seq = exp_seq_q;
      case (mode_q)
        MODE_LOAD: begin
          res_o.ack_size = ACK_SIZE_MEM;
          {res_o.ack_data_high, res_o.ack_data_low} = row_i[BUF_DEPTH-1:LOAD_DATA_LO];
        end
        MODE_RDCR: begin
          res_o.ack_size     = ACK_SIZE_CTRL;
          res_o.ack_data_low = 64'(row_i[BUF_DEPTH-1:RDCR_DATA_LO]);
        end
        MODE_WRCR: begin
          res_o.start_pulse = flush_q;
        end
        MODE_STOP: begin
          res_o.stop_pulse = 1'b1;
        end
        default: begin
          res_o.ack_size = '0;
        end
      endcase
    end

    if (!look) begin
      res_o.status = ST_NONE;
    end else if (!seq_ok) begin
      res_o.status = ST_SEQ_DROP;
    end else if (!ok) begin
      res_o.status = ST_CHECK_FAIL;
    end else begin
      res_o.status = ST_TAKEN;
    end

    ctl_o.load       = fire_i && take;
    ctl_o.skip_first = item_i.link_accepts;
    ctl_o.shift      = fire_i && (send_step || recv_step);
    ctl_o.shift_in   = item_i.link_reply_nibble;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_IDLE;
      exp_seq_q     <= 16'd1;
      flush_q       <= 1'b0;
      sent_q        <= '0;
      send_total_q  <= '0;
      recv_q        <= '0;
      recv_total_q  <= '0;
      send_valid_q  <= 1'b0;
      send_nib_q    <= '0;
      reply_ready_q <= 1'b0;
    end else if (fire_i) begin
      mode_q        <= mode_d;
      exp_seq_q     <= exp_seq_d;
      flush_q       <= flush_d;
      sent_q        <= sent_d;
      send_total_q  <= send_total_d;
      recv_q        <= recv_d;
      recv_total_q  <= recv_total_d;
      send_valid_q  <= send_valid_d;
      send_nib_q    <= send_nib_d;
      reply_ready_q <= reply_ready_d;
    end
  end

endmodule

>>> design/host_packet_nibble_link_bridge_unit.sv
// the result item of an accepted input item is registered and shown in the next cycle
// throughput: one item per cycle while m_axis_tready is high, input taken while the result register drains
// the nibble row shifts one place per link or reply nibble, one per item
// reset: control state cleared asynchronously, sequence number set to one
// the nibble row itself is not reset
// ----------------------------------------------------------------------------
// host_packet_nibble_link_bridge_unit
// Turns host packets into nibble frames on a link and returns acknowledgements.
// ----------------------------------------------------------------------------
module host_packet_nibble_link_bridge_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // packet_valid, command, packet_seq, address, payload_size, payload_low,
  // payload_high, link_accepts, link_reply_valid, link_reply_nibble
  input  logic [hpnlb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // send_valid, send_nibble, reply_ready, ack_valid, ack_seq, ack_size,
  // ack_data_low, ack_data_high, start_pulse, stop_pulse, status
  output logic [hpnlb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import hpnlb_pkg::*;

  in_item_t   in_item;
  out_item_t  res, out_q;
  chain_ctl_t ctl;
  row_t       row;
  logic       fire;
  logic       out_valid_q;

  assign in_item       = in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  hpnlb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item),
    .row_i  (row),
    .ctl_o  (ctl),
    .res_o  (res)
  );

  hpnlb_chain u_chain (
    .clk_i          (clk_i),
    .ctl_i          (ctl),
    .command_i      (in_item.command),
    .address_i      (in_item.address),
    .payload_low_i  (in_item.payload_low),
    .payload_high_i (in_item.payload_high),
    .row_o          (row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_q);

endmodule
